// File: hw/rtl/fixed_size_object_pool_allocator_defines.svh
// Assertion macros shared by the pool allocator RTL.
`ifndef FIXED_SIZE_OBJECT_POOL_ALLOCATOR_DEFINES_SVH
`define FIXED_SIZE_OBJECT_POOL_ALLOCATOR_DEFINES_SVH

// Checks a consequent in the same cycle as its antecedent.
`define FSPA_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pool allocator check failed");

// Checks a consequent in the cycle after its antecedent.
`define FSPA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pool allocator check failed");

`endif

// File: hw/rtl/fspa_pkg.sv
package fspa_pkg;

    localparam int CNT_W  = 13;
    localparam int ADDR_W = 32;
    localparam int RAW_W  = 13;
    localparam int ALOG_W = 4;
    localparam int HEAP_W = 25;
    localparam int SLOT_W = 16;
    localparam int BASE_W = 34;
    localparam int STAT_W = 3;
    localparam int ACT_W  = 2;
    localparam int PADDR_W = 5;

    localparam logic [ACT_W-1:0] ACT_ALLOC = 2'd0;
    localparam logic [ACT_W-1:0] ACT_FREE  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_ADD   = 2'd2;

    localparam logic [STAT_W-1:0] ST_DONE      = 3'd0;
    localparam logic [STAT_W-1:0] ST_COUNT_LIM = 3'd1;
    localparam logic [STAT_W-1:0] ST_HEAP_LIM  = 3'd2;
    localparam logic [STAT_W-1:0] ST_EXHAUSTED = 3'd3;
    localparam logic [STAT_W-1:0] ST_IGNORED   = 3'd4;

    localparam logic [2:0] REG_RAW_SIZE    = 3'd0;
    localparam logic [2:0] REG_ALIGN_LOG2  = 3'd1;
    localparam logic [2:0] REG_HEAP_BASE   = 3'd2;
    localparam logic [2:0] REG_HEAP_BYTES  = 3'd3;
    localparam logic [2:0] REG_CNT_LIM_ON  = 3'd4;
    localparam logic [2:0] REG_CNT_LIM     = 3'd5;
    localparam logic [2:0] REG_HEAP_LIM_ON = 3'd6;
    localparam logic [2:0] REG_HEAP_LIM    = 3'd7;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_CARVE_MUL,
        S_CARVE_CHK,
        S_CARVE_WR,
        S_POP_CHK,
        S_POP_RD,
        S_POP_MUL,
        S_POP_ADDR,
        S_FREE_DIV,
        S_FREE_UPD,
        S_DONE
    } state_t;

endpackage

// File: hw/rtl/fspa_ram.sv
module fspa_ram #(
    parameter int WIDTH = 13,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: hw/rtl/fspa_div.sv
module fspa_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [fspa_pkg::ADDR_W-1:0] dividend,
    input  logic [fspa_pkg::SLOT_W-1:0] divisor,
    output logic                      done,
    output logic [fspa_pkg::ADDR_W-1:0] quotient
);

    import fspa_pkg::*;

    logic [ADDR_W-1:0]  quo_reg, quo_next;
    logic [SLOT_W:0]    rem_reg, rem_next;
    logic [5:0]         cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [SLOT_W+1:0]  trial;
    logic [SLOT_W:0]    shifted;

    always_comb
    begin
        shifted   = {rem_reg[SLOT_W-1:0], quo_reg[ADDR_W-1]};
        trial     = {1'b0, shifted} - {2'b0, divisor};
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[SLOT_W+1])
            begin
                rem_next = trial[SLOT_W:0];
                quo_next = {quo_reg[ADDR_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted;
                quo_next = {quo_reg[ADDR_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'(ADDR_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// File: hw/rtl/fixed_size_object_pool_allocator.sv
// Fixed-size object pool: a free list of slots carved from a bump heap, one request at a time.
// An allocate pops the free-list head, first carving a slot when the list is empty, or is
// rejected by a limit; a free converts its address to a slot index in the 32-step divider,
// unless it is ignored; an add of n slots makes one link-memory write per slot. The input
// is not ready while a request is in work. A finished result is held in the output register,
// and a later request stalls before presenting its own result until that one is taken.
// Configure only while the block is idle.
`include "fixed_size_object_pool_allocator_defines.svh"

module fixed_size_object_pool_allocator #(
    parameter int MAX_SLOTS = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [fspa_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_tvalid,
    output logic        s_tready,
    // Fields from bit 0: action[1:0], object_addr[33:2], add_count[46:34], zero fill.
    input  logic [47:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // Fields from bit 0: status[2:0], alloc_addr[34:3], granted[47:35], used_count[60:48],
    // free_count[73:61], peak_count[86:74], zero fill.
    output logic [87:0] m_tdata
);

    import fspa_pkg::*;

    localparam int IW    = $clog2(MAX_SLOTS);
    localparam int IDX_W = IW + 1;
    localparam int MB_W  = (IDX_W > CNT_W) ? IDX_W : CNT_W;
    localparam int PR_W  = SLOT_W + MB_W;
    localparam logic [IDX_W-1:0] NULL_IDX = IDX_W'(MAX_SLOTS);

    // Configuration registers.
    logic [RAW_W-1:0]  raw_size_reg;
    logic [ALOG_W-1:0] align_log2_reg;
    logic [ADDR_W-1:0] heap_base_reg;
    logic [HEAP_W-1:0] heap_bytes_reg;
    logic              cnt_lim_on_reg;
    logic [CNT_W-1:0]  cnt_lim_reg;
    logic              heap_lim_on_reg;
    logic [HEAP_W-1:0] heap_lim_reg;
    logic              cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raw_size_reg    <= RAW_W'(4);
            align_log2_reg  <= ALOG_W'(2);
            heap_base_reg   <= '0;
            heap_bytes_reg  <= '0;
            cnt_lim_on_reg  <= 1'b0;
            cnt_lim_reg     <= CNT_W'(4096);
            heap_lim_on_reg <= 1'b0;
            heap_lim_reg    <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[4:2])
                REG_RAW_SIZE:    raw_size_reg    <= pwdata[RAW_W-1:0];
                REG_ALIGN_LOG2:  align_log2_reg  <= pwdata[ALOG_W-1:0];
                REG_HEAP_BASE:   heap_base_reg   <= pwdata;
                REG_HEAP_BYTES:  heap_bytes_reg  <= pwdata[HEAP_W-1:0];
                REG_CNT_LIM_ON:  cnt_lim_on_reg  <= pwdata[0];
                REG_CNT_LIM:     cnt_lim_reg     <= pwdata[CNT_W-1:0];
                REG_HEAP_LIM_ON: heap_lim_on_reg <= pwdata[0];
                REG_HEAP_LIM:    heap_lim_reg    <= pwdata[HEAP_W-1:0];
                default:         heap_lim_reg    <= heap_lim_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[4:2])
            REG_RAW_SIZE:    prdata = 32'(raw_size_reg);
            REG_ALIGN_LOG2:  prdata = 32'(align_log2_reg);
            REG_HEAP_BASE:   prdata = heap_base_reg;
            REG_HEAP_BYTES:  prdata = 32'(heap_bytes_reg);
            REG_CNT_LIM_ON:  prdata = 32'(cnt_lim_on_reg);
            REG_CNT_LIM:     prdata = 32'(cnt_lim_reg);
            REG_HEAP_LIM_ON: prdata = 32'(heap_lim_on_reg);
            REG_HEAP_LIM:    prdata = 32'(heap_lim_reg);
            default:         prdata = '0;
        endcase
    end

    // Slot geometry from the current registers.
    logic [ALOG_W-1:0] alog;
    logic [SLOT_W-1:0] al_mask;
    logic [RAW_W-1:0]  raw_min;
    logic [SLOT_W:0]   slot_sum;
    logic [SLOT_W-1:0] slot_size;
    logic [BASE_W-1:0] base_sum;
    logic [BASE_W-1:0] aligned_base;
    logic [HEAP_W-1:0] avail;

    // Pool state.
    state_t            state_reg, state_next;
    logic [IDX_W-1:0]  head_reg, head_next;
    logic              head_valid_reg, head_valid_next;
    logic [HEAP_W-1:0] cursor_reg, cursor_next;
    logic [IDX_W-1:0]  carved_reg, carved_next;
    logic [IDX_W-1:0]  used_reg, used_next;
    logic [IDX_W-1:0]  free_reg, free_next;
    logic [IDX_W-1:0]  peak_reg, peak_next;
    logic              frz_valid_reg, frz_valid_next;
    logic [IDX_W-1:0]  frz_lim_reg, frz_lim_next;

    // Request working registers.
    logic [ACT_W-1:0]  act_reg, act_next;
    logic [ADDR_W-1:0] obj_reg, obj_next;
    logic [CNT_W-1:0]  n_reg, n_next;
    logic [BASE_W-1:0] start_reg, start_next;
    logic [PR_W-1:0]   prod_reg, prod_next;
    logic [IDX_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [IDX_W-1:0]  last_reg, last_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [STAT_W-1:0] res_st_reg, res_st_next;
    logic [ADDR_W-1:0] res_addr_reg, res_addr_next;
    logic [CNT_W-1:0]  res_gr_reg, res_gr_next;

    logic              m_valid_reg, m_valid_next;
    logic [87:0]       m_data_reg, m_data_next;

    // Shared multiplier operands, link memory and divider hookup.
    logic [MB_W-1:0]   mul_b;
    logic              ram_we;
    logic [IW-1:0]     ram_waddr;
    logic [IDX_W-1:0]  ram_wdata;
    logic [IDX_W-1:0]  ram_rdata;
    logic              div_start;
    logic              div_done;
    logic [ADDR_W-1:0] div_q;
    logic [BASE_W-1:0] abs_pos;
    logic [BASE_W-1:0] abs_al;
    logic [39:0]       room;
    logic              frz_v_eval;
    logic [IDX_W-1:0]  frz_l_eval;
    logic [IDX_W-1:0]  head_or_null;

    always_comb
    begin
        alog      = (align_log2_reg < ALOG_W'(2)) ? ALOG_W'(2) : align_log2_reg;
        al_mask   = SLOT_W'((17'd1 << alog) - 17'd1);
        raw_min   = (raw_size_reg < RAW_W'(4)) ? RAW_W'(4) : raw_size_reg;
        slot_sum  = (SLOT_W+1)'(raw_min) + (SLOT_W+1)'(al_mask);
        slot_size = slot_sum[SLOT_W-1:0] & ~al_mask;
        base_sum  = BASE_W'(heap_base_reg) + BASE_W'(al_mask);
        aligned_base = base_sum & ~BASE_W'(al_mask);
        avail     = (cursor_reg <= heap_bytes_reg) ? heap_bytes_reg - cursor_reg : '0;
        abs_pos   = BASE_W'(heap_base_reg) + BASE_W'(cursor_reg) + BASE_W'(al_mask);
        abs_al    = abs_pos & ~BASE_W'(al_mask);
        head_or_null = head_valid_reg ? head_reg : NULL_IDX;
    end

    fspa_ram #(
        .WIDTH (IDX_W),
        .DEPTH (MAX_SLOTS)
    ) u_link (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (head_reg[IW-1:0]),
        .rdata (ram_rdata)
    );

    fspa_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (obj_reg - aligned_base[ADDR_W-1:0]),
        .divisor  (slot_size),
        .done     (div_done),
        .quotient (div_q)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        head_valid_next = head_valid_reg;
        cursor_next     = cursor_reg;
        carved_next     = carved_reg;
        used_next       = used_reg;
        free_next       = free_reg;
        peak_next       = peak_reg;
        frz_valid_next  = frz_valid_reg;
        frz_lim_next    = frz_lim_reg;
        act_next        = act_reg;
        obj_next        = obj_reg;
        n_next          = n_reg;
        start_next      = start_reg;
        prod_next       = prod_reg;
        wr_ptr_next     = wr_ptr_reg;
        last_next       = last_reg;
        idx_next        = idx_reg;
        res_st_next     = res_st_reg;
        res_addr_next   = res_addr_reg;
        res_gr_next     = res_gr_reg;
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;
        mul_b           = (state_reg == S_POP_MUL) ? MB_W'(idx_reg) : MB_W'(n_reg);
        ram_we          = 1'b0;
        ram_waddr       = wr_ptr_reg[IW-1:0];
        ram_wdata       = (wr_ptr_reg == last_reg) ? head_or_null : wr_ptr_reg + IDX_W'(1);
        div_start       = 1'b0;
        room            = 40'(heap_bytes_reg) - 40'(start_reg);
        frz_v_eval      = frz_valid_reg;
        frz_l_eval      = frz_lim_reg;

        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    act_next    = s_tdata[1:0];
                    obj_next    = s_tdata[33:2];
                    n_next      = s_tdata[46:34];
                    res_st_next = ST_IGNORED;
                    res_addr_next = '0;
                    res_gr_next = '0;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                start_next = abs_al - BASE_W'(heap_base_reg);
                state_next = S_DONE;
                unique case (act_reg)
                    ACT_ALLOC:
                    begin
                        if (cnt_lim_on_reg && (32'(used_reg) >= 32'(cnt_lim_reg)))
                        begin
                            res_st_next = ST_COUNT_LIM;
                        end
                        else
                        begin
                            if (heap_lim_on_reg)
                            begin
                                if (!frz_valid_reg)
                                begin
                                    if (avail <= heap_lim_reg)
                                    begin
                                        frz_v_eval = 1'b1;
                                        frz_l_eval = used_reg + free_reg;
                                    end
                                end
                                else if (avail > heap_lim_reg)
                                begin
                                    frz_v_eval = 1'b0;
                                end
                            end
                            frz_valid_next = frz_v_eval;
                            frz_lim_next   = frz_l_eval;
                            if (heap_lim_on_reg && frz_v_eval && (used_reg >= frz_l_eval))
                            begin
                                res_st_next = ST_HEAP_LIM;
                            end
                            else if (free_reg == '0)
                            begin
                                n_next     = CNT_W'(1);
                                state_next = S_CARVE_MUL;
                            end
                            else
                            begin
                                state_next = S_POP_CHK;
                            end
                        end
                    end
                    ACT_FREE:
                    begin
                        if ((obj_reg != '0) && (used_reg != '0)
                            && (BASE_W'(obj_reg) >= aligned_base))
                        begin
                            div_start  = 1'b1;
                            state_next = S_FREE_DIV;
                        end
                    end
                    ACT_ADD:
                    begin
                        if (n_reg != '0)
                        begin
                            state_next = S_CARVE_MUL;
                        end
                    end
                    default:
                    begin
                        res_st_next = ST_IGNORED;
                    end
                endcase
            end
            S_CARVE_MUL:
            begin
                prod_next  = PR_W'(slot_size) * PR_W'(mul_b);
                state_next = S_CARVE_CHK;
            end
            S_CARVE_CHK:
            begin
                if ((32'(carved_reg) + 32'(n_reg) > 32'(MAX_SLOTS))
                    || (start_reg > BASE_W'(heap_bytes_reg))
                    || (40'(prod_reg) > room))
                begin
                    res_st_next = ST_EXHAUSTED;
                    state_next  = S_DONE;
                end
                else
                begin
                    wr_ptr_next = carved_reg;
                    last_next   = carved_reg + IDX_W'(n_reg) - IDX_W'(1);
                    state_next  = S_CARVE_WR;
                end
            end
            S_CARVE_WR:
            begin
                ram_we      = 1'b1;
                wr_ptr_next = wr_ptr_reg + IDX_W'(1);
                if (wr_ptr_reg == last_reg)
                begin
                    head_next       = carved_reg;
                    head_valid_next = 1'b1;
                    carved_next     = carved_reg + IDX_W'(n_reg);
                    free_next       = free_reg + IDX_W'(n_reg);
                    cursor_next     = HEAP_W'(start_reg + BASE_W'(prod_reg));
                    if (act_reg == ACT_ALLOC)
                    begin
                        state_next = S_POP_CHK;
                    end
                    else
                    begin
                        res_st_next = ST_DONE;
                        res_gr_next = n_reg;
                        state_next  = S_DONE;
                    end
                end
            end
            S_POP_CHK:
            begin
                if (head_valid_reg && (head_reg < NULL_IDX))
                begin
                    state_next = S_POP_RD;
                end
                else
                begin
                    res_st_next = ST_EXHAUSTED;
                    state_next  = S_DONE;
                end
            end
            S_POP_RD:
            begin
                idx_next        = head_reg;
                head_next       = ram_rdata;
                head_valid_next = ram_rdata < NULL_IDX;
                used_next       = used_reg + IDX_W'(1);
                free_next       = free_reg - IDX_W'(1);
                if (used_reg + IDX_W'(1) > peak_reg)
                begin
                    peak_next = used_reg + IDX_W'(1);
                end
                state_next = S_POP_MUL;
            end
            S_POP_MUL:
            begin
                prod_next  = PR_W'(slot_size) * PR_W'(mul_b);
                state_next = S_POP_ADDR;
            end
            S_POP_ADDR:
            begin
                res_st_next   = ST_DONE;
                res_addr_next = ADDR_W'(aligned_base + BASE_W'(prod_reg));
                state_next    = S_DONE;
            end
            S_FREE_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_FREE_UPD;
                end
            end
            S_FREE_UPD:
            begin
                if (32'(div_q) < 32'(carved_reg))
                begin
                    ram_we          = 1'b1;
                    ram_waddr       = div_q[IW-1:0];
                    ram_wdata       = head_or_null;
                    head_next       = IDX_W'(div_q);
                    head_valid_next = 1'b1;
                    free_next       = free_reg + IDX_W'(1);
                    used_next       = used_reg - IDX_W'(1);
                    res_st_next     = ST_DONE;
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = {1'b0, CNT_W'(peak_reg), CNT_W'(free_reg),
                                    CNT_W'(used_reg), res_gr_reg, res_addr_reg, res_st_reg};
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            head_reg       <= NULL_IDX;
            head_valid_reg <= 1'b0;
            cursor_reg     <= '0;
            carved_reg     <= '0;
            used_reg       <= '0;
            free_reg       <= '0;
            peak_reg       <= '0;
            frz_valid_reg  <= 1'b0;
            frz_lim_reg    <= '1;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            head_reg       <= head_next;
            head_valid_reg <= head_valid_next;
            cursor_reg     <= cursor_next;
            carved_reg     <= carved_next;
            used_reg       <= used_next;
            free_reg       <= free_next;
            peak_reg       <= peak_next;
            frz_valid_reg  <= frz_valid_next;
            frz_lim_reg    <= frz_lim_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg      <= act_next;
        obj_reg      <= obj_next;
        n_reg        <= n_next;
        start_reg    <= start_next;
        prod_reg     <= prod_next;
        wr_ptr_reg   <= wr_ptr_next;
        last_reg     <= last_next;
        idx_reg      <= idx_next;
        res_st_reg   <= res_st_next;
        res_addr_reg <= res_addr_next;
        res_gr_reg   <= res_gr_next;
        m_data_reg   <= m_data_next;
    end

    `FSPA_ASSERT_NOW(a_free_le_carved, 1'b1, free_reg <= carved_reg)
    `FSPA_ASSERT_NOW(a_sum_le_carved, 1'b1,
        (32'(used_reg) + 32'(free_reg)) <= 32'(carved_reg))
    `FSPA_ASSERT_NOW(a_peak_ge_used, 1'b1, peak_reg >= used_reg)
    `FSPA_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)

endmodule
